>>> src/gps_pkg.sv
// Package for the greedy phrase selector: phase encoding and sizing constants.
// No dependencies; used by the interfaces, the top level and the checker.
package gps_pkg;

  localparam int POS_BITS_DEF = 32;  // default position width
  localparam int SRC_BITS     = 32;  // source position width
  localparam int MAX_RES      = 3;   // results one transaction can produce
  localparam int RES_DEPTH    = 4;   // result queue entries

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,  // waiting for the first phrase of a list
    PH_SKIP = 2'd1,  // dropping phrases that end before the current end
    PH_SCAN = 2'd2   // scanning followers of the current phrase
  } phase_t;

endpackage

>>> src/gps_if.sv
// Valid/ready channel interfaces for the greedy phrase selector.
// Depends on gps_pkg for default widths.
interface gps_in_if #(
  parameter int POS_BITS = gps_pkg::POS_BITS_DEF
);
  import gps_pkg::*;
  logic                valid;
  logic                ready;
  logic [POS_BITS-1:0] phrase_begin;
  logic [POS_BITS-1:0] phrase_end;
  logic [SRC_BITS-1:0] phrase_source;
  logic                is_final;

  modport source (output valid, phrase_begin, phrase_end, phrase_source, is_final,
                  input ready);
  modport sink   (input valid, phrase_begin, phrase_end, phrase_source, is_final,
                  output ready);
endinterface

interface gps_out_if #(
  parameter int POS_BITS = gps_pkg::POS_BITS_DEF
);
  import gps_pkg::*;
  logic                valid;
  logic                ready;
  logic [POS_BITS-1:0] out_begin;
  logic [POS_BITS-1:0] out_end;
  logic [SRC_BITS-1:0] out_source;
  logic                out_final;

  modport source (output valid, out_begin, out_end, out_source, out_final,
                  input ready);
  modport sink   (input valid, out_begin, out_end, out_source, out_final,
                  output ready);
endinterface

>>> src/greedy_phrase_selector.sv
// Greedy phrase selector: picks a non-overlapping chain of copy phrases from a
// sorted candidate stream. One transaction is taken per cycle whenever the
// result queue has room for three results; each transaction yields zero to
// three results, which leave one per cycle while the output port is ready, so
// the output sets the rate when candidates produce more than one result each.
// A result enters the result queue the cycle after its transaction and is on
// the output once earlier results have left. Depends on gps_pkg and gps_if.
module greedy_phrase_selector #(
  parameter int POS_BITS = gps_pkg::POS_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  gps_in_if.sink    in_ch,
  gps_out_if.source out_ch
);
  import gps_pkg::*;

  localparam int PTR_W = $clog2(RES_DEPTH);
  localparam int CNT_W = $clog2(RES_DEPTH + 1);

  // phrase state
  phase_t              phase_r, phase_nxt;
  logic [POS_BITS-1:0] cur_b_r, cur_b_nxt, cur_e_r, cur_e_nxt;
  logic [SRC_BITS-1:0] cur_s_r, cur_s_nxt;
  logic [POS_BITS-1:0] best_b_r, best_b_nxt, best_e_r, best_e_nxt;
  logic [SRC_BITS-1:0] best_s_r, best_s_nxt;

  // result queue
  logic [POS_BITS-1:0] q_beg_r [RES_DEPTH];
  logic [POS_BITS-1:0] q_end_r [RES_DEPTH];
  logic [SRC_BITS-1:0] q_src_r [RES_DEPTH];
  logic                q_fin_r [RES_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  // results of the current transaction, in emission order
  logic                sl_v   [MAX_RES];
  logic [POS_BITS-1:0] sl_beg [MAX_RES];
  logic [POS_BITS-1:0] sl_end [MAX_RES];
  logic [SRC_BITS-1:0] sl_src [MAX_RES];
  logic                sl_fin [MAX_RES];
  logic [1:0]          sl_off [MAX_RES];
  logic [1:0]          push_n;

  logic                in_acc, out_acc;
  logic [POS_BITS-1:0] ib, ie;
  logic [SRC_BITS-1:0] is;
  logic                ifin;

  assign ib   = in_ch.phrase_begin;
  assign ie   = in_ch.phrase_end;
  assign is   = in_ch.phrase_source;
  assign ifin = in_ch.is_final;

  assign in_ch.ready = (cnt_r <= CNT_W'(RES_DEPTH - MAX_RES));
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_ch.valid && out_ch.ready;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_acc) begin
      case (phase_r)
        PH_SKIP: begin
          if (ie < cur_e_r) begin
            phase_nxt = ifin ? PH_IDLE : PH_SKIP;
          end else begin
            phase_nxt = ifin ? PH_IDLE : PH_SCAN;
          end
        end
        PH_SCAN: phase_nxt = ifin ? PH_IDLE : PH_SCAN;
        default: phase_nxt = ifin ? PH_IDLE : PH_SKIP;
      endcase
    end
  end

  // phrase datapath and results
  always_comb begin
    logic [POS_BITS-1:0] cut_e, nb_b, nb_e, h_b, h_e;
    logic [SRC_BITS-1:0] nb_s, h_s;

    cur_b_nxt  = cur_b_r;
    cur_e_nxt  = cur_e_r;
    cur_s_nxt  = cur_s_r;
    best_b_nxt = best_b_r;
    best_e_nxt = best_e_r;
    best_s_nxt = best_s_r;
    cut_e = '0;
    nb_b  = best_b_r;
    nb_e  = best_e_r;
    nb_s  = best_s_r;
    h_b   = ib;
    h_e   = ie;
    h_s   = is;
    for (int k = 0; k < MAX_RES; k++) begin
      sl_v[k]   = 1'b0;
      sl_beg[k] = ib;
      sl_end[k] = ie;
      sl_src[k] = is;
      sl_fin[k] = 1'b1;
    end

    case (phase_r)
      PH_SKIP: begin
        if (ie < cur_e_r) begin
          // contained phrase: drop, flush the current one on the last item
          sl_v[2]   = ifin;
          sl_beg[2] = cur_b_r;
          sl_end[2] = cur_e_r;
          sl_src[2] = cur_s_r;
        end else begin
          best_b_nxt = ib;
          best_e_nxt = ie;
          best_s_nxt = is;
          cut_e      = (ib < cur_e_r) ? ib : cur_e_r;
          sl_v[0]    = ifin && (cut_e > cur_b_r);
          sl_beg[0]  = cur_b_r;
          sl_end[0]  = cut_e;
          sl_src[0]  = cur_s_r;
          sl_fin[0]  = 1'b0;
          sl_v[2]    = ifin;
        end
      end
      PH_SCAN: begin
        if (ib <= cur_e_r) begin
          if (ie > best_e_r) begin
            nb_b = ib;
            nb_e = ie;
            nb_s = is;
          end
          best_b_nxt = nb_b;
          best_e_nxt = nb_e;
          best_s_nxt = nb_s;
          cut_e      = (nb_b < cur_e_r) ? nb_b : cur_e_r;
          sl_v[0]    = ifin && (nb_e > cur_e_r) && (cut_e > cur_b_r);
          sl_beg[0]  = cur_b_r;
          sl_end[0]  = cut_e;
          sl_src[0]  = cur_s_r;
          sl_fin[0]  = 1'b0;
          sl_v[2]    = ifin;
          if (nb_e > cur_e_r) begin
            sl_beg[2] = nb_b;
            sl_end[2] = nb_e;
            sl_src[2] = nb_s;
          end else begin
            sl_beg[2] = cur_b_r;
            sl_end[2] = cur_e_r;
            sl_src[2] = cur_s_r;
          end
        end else begin
          // item starts past the current end: hand over
          if (best_e_r > cur_e_r) begin
            cut_e = (best_b_r < cur_e_r) ? best_b_r : cur_e_r;
            h_b   = best_b_r;
            h_e   = best_e_r;
            h_s   = best_s_r;
          end else begin
            cut_e = (ib < cur_e_r) ? ib : cur_e_r;
          end
          sl_v[0]    = cut_e > cur_b_r;
          sl_beg[0]  = cur_b_r;
          sl_end[0]  = cut_e;
          sl_src[0]  = cur_s_r;
          sl_fin[0]  = 1'b0;
          cur_b_nxt  = h_b;
          cur_e_nxt  = h_e;
          cur_s_nxt  = h_s;
          best_b_nxt = ib;
          best_e_nxt = ie;
          best_s_nxt = is;
          // last item: cut the new current phrase at the item's begin
          sl_beg[1]  = h_b;
          sl_end[1]  = (ib < h_e) ? ib : h_e;
          sl_src[1]  = h_s;
          sl_fin[1]  = 1'b0;
          sl_v[1]    = ifin && (sl_end[1] > h_b);
          sl_v[2]    = ifin;
        end
      end
      default: begin
        cur_b_nxt = ib;
        cur_e_nxt = ie;
        cur_s_nxt = is;
        sl_v[2]   = ifin;
      end
    endcase

    sl_off[0] = 2'd0;
    sl_off[1] = {1'b0, sl_v[0]};
    sl_off[2] = {1'b0, sl_v[0]} + {1'b0, sl_v[1]};
    push_n    = sl_off[2] + {1'b0, sl_v[2]};
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc) begin
      cnt_nxt = cnt_nxt + CNT_W'(push_n);
    end
    if (out_acc) begin
      cnt_nxt = cnt_nxt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      if (in_acc) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(push_n);
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_b_r  <= cur_b_nxt;
      cur_e_r  <= cur_e_nxt;
      cur_s_r  <= cur_s_nxt;
      best_b_r <= best_b_nxt;
      best_e_r <= best_e_nxt;
      best_s_r <= best_s_nxt;
      for (int k = 0; k < MAX_RES; k++) begin
        if (sl_v[k]) begin
          q_beg_r[wr_ptr_r + PTR_W'(sl_off[k])] <= sl_beg[k];
          q_end_r[wr_ptr_r + PTR_W'(sl_off[k])] <= sl_end[k];
          q_src_r[wr_ptr_r + PTR_W'(sl_off[k])] <= sl_src[k];
          q_fin_r[wr_ptr_r + PTR_W'(sl_off[k])] <= sl_fin[k];
        end
      end
    end
  end

  assign out_ch.valid      = (cnt_r != '0);
  assign out_ch.out_begin  = q_beg_r[rd_ptr_r];
  assign out_ch.out_end    = q_end_r[rd_ptr_r];
  assign out_ch.out_source = q_src_r[rd_ptr_r];
  assign out_ch.out_final  = q_fin_r[rd_ptr_r];

endmodule

>>> src/gps_checker.sv
// Port-level checks for greedy_phrase_selector, bound to the top level.
// Depends on gps_pkg for the default position width.
module gps_checker #(
  parameter int POS_BITS = gps_pkg::POS_BITS_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_final,
  input logic                out_valid,
  input logic                out_ready,
  input logic [POS_BITS-1:0] out_begin
);

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // the last candidate of a list always produces a result
  a_final_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_final |=> out_valid)
    else $error("final transaction gave no result");

  // backpressure on the input only while results wait
  a_stall_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_begin))
    else $error("stalled result changed");

endmodule

bind greedy_phrase_selector gps_checker #(.POS_BITS(POS_BITS)) u_gps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_final  (in_ch.is_final),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_begin (out_ch.out_begin)
);
